### hdl/class_preferring_ticket_queue_top_macros.svh
// assertion helpers for the ticket queue
`ifndef CLASS_PREFERRING_TICKET_QUEUE_TOP_MACROS_SVH
`define CLASS_PREFERRING_TICKET_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define CPTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cptq_pkg.sv
package cptq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CLASS_W  = 8;
  localparam int SERVER_W = 4;
  localparam int TICKET_W = 16;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_DATA_W = 8;

  localparam logic [TICKET_W-1:0] TICKET_RESET    = 16'd1;
  localparam logic [SERVER_W-1:0] PREF_SERVER_RST = 4'd1;
  localparam logic [CLASS_W-1:0]  PRIO_CLASS_RST  = 8'd80;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CALL   = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    CFG_PREF_SERVER = 1'b0,
    CFG_PRIO_CLASS  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cptq_cmd_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [OCC_W-1:0] occ;
  } cptq_stat_t;

endpackage

### hdl/cptq_ctrl.sv
module cptq_ctrl
  import cptq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output cptq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/cptq_datapath.sv
module cptq_datapath
  import cptq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cptq_cmd_t             cmd,
  input  logic                  in_op,
  input  logic [CLASS_W-1:0]    in_class,
  input  logic [SERVER_W-1:0]   in_server,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output status_t               res_status,
  output logic [CLASS_W-1:0]    res_class,
  output logic [TICKET_W-1:0]   res_ticket,
  output logic [SERVER_W-1:0]   res_by,
  output cptq_stat_t            stat
);

  logic [CLASS_W-1:0]  slot_class  [QUEUE_DEPTH];
  logic [TICKET_W-1:0] slot_ticket [QUEUE_DEPTH];
  logic [OCC_W-1:0]    occ;
  logic [TICKET_W-1:0] next_ticket;
  logic [SERVER_W-1:0] pref_server;
  logic [CLASS_W-1:0]  prio_class;

  op_t                 req_op;
  logic [CLASS_W-1:0]  req_class;
  logic [SERVER_W-1:0] req_server;
  logic [IDX_W-1:0]    req_pick;
  logic [CLASS_W-1:0]  req_pick_class;
  logic [TICKET_W-1:0] req_pick_ticket;

  logic [QUEUE_DEPTH-1:0] match;
  logic [IDX_W-1:0]       pick;
  logic                   full;
  logic                   empty;

  assign full  = (occ == OCC_W'(QUEUE_DEPTH));
  assign empty = (occ == '0);

  assign stat.full  = full;
  assign stat.empty = empty;
  assign stat.occ   = occ;

  // priority class match over the live slots
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (slot_class[i] == prio_class) && (OCC_W'(i) < occ);
    end
  end

  // oldest match wins, slot 0 when not preferred or no match
  always_comb begin
    pick = '0;
    if (in_server == pref_server) begin
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
        if (match[i]) begin
          pick = IDX_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pref_server <= PREF_SERVER_RST;
      prio_class  <= PRIO_CLASS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_PREF_SERVER: pref_server <= cfg_wdata[SERVER_W-1:0];
        CFG_PRIO_CLASS:  prio_class  <= cfg_wdata[CLASS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op          <= op_t'(in_op);
      req_class       <= in_class;
      req_server      <= in_server;
      req_pick        <= pick;
      req_pick_class  <= slot_class[pick];
      req_pick_ticket <= slot_ticket[pick];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ         <= '0;
      next_ticket <= TICKET_RESET;
    end else if (cmd.commit) begin
      if (req_op == OP_INSERT) begin
        if (!full) begin
          occ         <= occ + 1'b1;
          next_ticket <= next_ticket + 1'b1;
        end
      end else if (!empty) begin
        occ <= occ - 1'b1;
      end
    end
  end

  // slot row: append at tail, collapse forward from the picked slot
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req_op == OP_INSERT) begin
        if (!full) begin
          slot_class[occ[IDX_W-1:0]]  <= req_class;
          slot_ticket[occ[IDX_W-1:0]] <= next_ticket;
        end
      end else if (!empty) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (IDX_W'(i) >= req_pick) begin
            slot_class[i]  <= slot_class[i+1];
            slot_ticket[i] <= slot_ticket[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req_op == OP_INSERT) begin
        res_by    <= '0;
        res_class <= req_class;
        if (full) begin
          res_status <= ST_FULL;
          res_ticket <= '0;
        end else begin
          res_status <= ST_INSERTED;
          res_ticket <= next_ticket;
        end
      end else begin
        res_by <= req_server;
        if (empty) begin
          res_status <= ST_EMPTY;
          res_class  <= '0;
          res_ticket <= '0;
        end else begin
          res_status <= ST_SERVED;
          res_class  <= req_pick_class;
          res_ticket <= req_pick_ticket;
        end
      end
    end
  end

endmodule

### hdl/class_preferring_ticket_queue_top.sv
// class preferring ticket queue
// s_tuser carries the operation (insert or call), s_tdata the class code and
// the calling server. every transfer in gives exactly one result transfer on
// m_tuser (status) and m_tdata (class, ticket, server).
// the config port writes the preferred server (index 0) and the priority
// class code (index 1); write only while the queue is idle.
// an item passes through the transfer, where the priority class match and
// priority encoder over the 16 slots run, and then the execute state, where
// the slot row appends or collapses and the result register loads.
// m_tvalid rises when the result register loads; a new item is taken only
// once the last one has left the execute state.
// the result register parts the two sides: a new item is taken while a
// result waits, but its execute state holds until the result register frees.
// reset empties the queue, sets the next ticket to 1 and restores the
// register defaults; slot contents need no clearing.
module class_preferring_ticket_queue_top
  import cptq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // class_code[7:0], server_id[11:8]
  input  logic                  s_tuser,   // op[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // served_class[7:0], served_ticket[23:8],
                                           // served_by[27:24]
  output logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int OUT_PAD_W = OUT_DATA_W - CLASS_W - TICKET_W - SERVER_W;

  cptq_cmd_t           cmd;
  cptq_stat_t          stat;
  status_t             res_status;
  logic [CLASS_W-1:0]  res_class;
  logic [TICKET_W-1:0] res_ticket;
  logic [SERVER_W-1:0] res_by;

  cptq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  cptq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_op      (s_tuser),
    .in_class   (s_tdata[CLASS_W-1:0]),
    .in_server  (s_tdata[CLASS_W+SERVER_W-1:CLASS_W]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .res_status (res_status),
    .res_class  (res_class),
    .res_ticket (res_ticket),
    .res_by     (res_by),
    .stat       (stat)
  );

  assign m_tuser = res_status;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, res_by, res_ticket, res_class};

`include "class_preferring_ticket_queue_top_macros.svh"

  `CPTQ_ASSERT_NOW(a_occ_bound, 1'b1, stat.occ <= OCC_W'(QUEUE_DEPTH), "occupancy above depth")
  `CPTQ_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `CPTQ_ASSERT_NEXT(a_served_result, cmd.commit && !stat.empty && $past(s_tuser && cmd.load), m_tvalid && (m_tuser == ST_SERVED), "call on non-empty queue not served")
  `CPTQ_ASSERT_NOW(a_no_load_in_exec, cmd.commit, !cmd.load, "item taken during execute")

endmodule
